>>> rtl/dsw_pkg.sv
// Shared types, constants and the digit-to-segment function for the
// debounced four-digit stopwatch. No dependencies.
package dsw_pkg;

  localparam int DEBOUNCE_BITS = 8;
  localparam int THR_W         = 8;
  localparam int CMP_W         = (DEBOUNCE_BITS > THR_W) ? DEBOUNCE_BITS : THR_W;
  localparam int DIGITS        = 4;
  localparam int DIGIT_W       = 4;
  localparam int SEG_W         = 7;
  localparam int SHOWN_W       = 14;

  localparam logic [THR_W-1:0]   THR_RESET = THR_W'(3);
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = DIGIT_W'(9);

  typedef logic [DEBOUNCE_BITS-1:0] press_cnt_t;
  typedef logic [THR_W-1:0]         thr_t;
  typedef logic [DIGIT_W-1:0]       digit_t;
  typedef logic [SEG_W-1:0]         seg_t;

  typedef struct packed {
    logic start_pressed;
    logic stop_pressed;
    logic clear_pressed;
  } in_t;

  typedef struct packed {
    seg_t                 seg_thousands;
    seg_t                 seg_hundreds;
    seg_t                 seg_tens;
    seg_t                 seg_units;
    logic [SHOWN_W-1:0]   shown_count;
    logic                 is_running;
  } out_t;

  function automatic seg_t seg_decode(input digit_t d);
    seg_t s;
    case (d)
      4'd0: s = 7'h3F;
      4'd1: s = 7'h06;
      4'd2: s = 7'h5B;
      4'd3: s = 7'h4F;
      4'd4: s = 7'h66;
      4'd5: s = 7'h6D;
      4'd6: s = 7'h7D;
      4'd7: s = 7'h07;
      4'd8: s = 7'h7F;
      4'd9: s = 7'h6F;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/dsw_debounce.sv
// Press counter for one button: counts held ticks, saturates at the
// threshold and flags the tick on which the action fires. Uses dsw_pkg.
module dsw_debounce (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         level,
  input  dsw_pkg::thr_t thr,
  output logic         fire
);
  import dsw_pkg::*;

  press_cnt_t       cnt_r;
  press_cnt_t       cnt_nxt;
  logic [CMP_W-1:0] thr_eff;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] cnt_inc;

  always_comb begin
    thr_eff = (thr == '0) ? CMP_W'(1) : CMP_W'(thr);
    cnt_ext = CMP_W'(cnt_r);
    cnt_inc = cnt_ext + CMP_W'(1);
    cnt_nxt = cnt_r;
    fire    = 1'b0;
    if (!level) begin
      cnt_nxt = '0;
    end else if ((cnt_ext < thr_eff) && (cnt_r != '1)) begin
      cnt_nxt = cnt_r + press_cnt_t'(1);
      fire    = (cnt_inc == thr_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (en) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> rtl/debounced_stopwatch_7seg.sv
// Top level of the debounced four-digit BCD stopwatch with seven-segment
// output. Uses dsw_pkg and dsw_debounce.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid / in_ready    | in_data  (in_t)
//   out     | output    | out_valid / out_ready  | out_data (out_t)
//   cfg     | input     | cfg_valid / cfg_ready  | cfg_data (debounce threshold)
//
// Each tick's result is registered as the tick is taken and sits in the output
// register the next cycle; one transfer per clock while out_ready is high.
// The input is taken whenever the output register is empty or being drained.
// Synchronous reset clears the count, running flag and press counters and
// sets the threshold to three. The cfg port is always ready.
module debounced_stopwatch_7seg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dsw_pkg::in_t         in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dsw_pkg::out_t        out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  dsw_pkg::thr_t        cfg_data
);
  import dsw_pkg::*;

  thr_t   thr_r;
  logic   running_r;
  logic   running_nxt;
  digit_t digits_r   [DIGITS];
  digit_t digits_nxt [DIGITS];
  logic   out_valid_r;
  out_t   out_r;
  out_t   out_nxt;
  logic   accept;
  logic   fire_start;
  logic   fire_stop;
  logic   fire_clear;
  logic   carry;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  dsw_debounce u_start (
    .clk(clk), .rst_n(rst_n), .en(accept),
    .level(in_data.start_pressed), .thr(thr_r), .fire(fire_start)
  );
  dsw_debounce u_stop (
    .clk(clk), .rst_n(rst_n), .en(accept),
    .level(in_data.stop_pressed), .thr(thr_r), .fire(fire_stop)
  );
  dsw_debounce u_clear (
    .clk(clk), .rst_n(rst_n), .en(accept),
    .level(in_data.clear_pressed), .thr(thr_r), .fire(fire_clear)
  );

  always_comb begin
    running_nxt = running_r;
    if (fire_start) begin
      running_nxt = 1'b1;
    end
    if (fire_stop || fire_clear) begin
      running_nxt = 1'b0;
    end
    for (int i = 0; i < DIGITS; i++) begin
      digits_nxt[i] = fire_clear ? '0 : digits_r[i];
    end
    carry = running_nxt;
    for (int i = DIGITS - 1; i >= 0; i--) begin
      if (carry) begin
        if (digits_nxt[i] >= DIGIT_MAX) begin
          digits_nxt[i] = '0;
        end else begin
          digits_nxt[i] = digits_nxt[i] + digit_t'(1);
          carry         = 1'b0;
        end
      end
    end
  end

  always_comb begin
    out_nxt.seg_thousands = seg_decode(digits_r[0]);
    out_nxt.seg_hundreds  = seg_decode(digits_r[1]);
    out_nxt.seg_tens      = seg_decode(digits_r[2]);
    out_nxt.seg_units     = seg_decode(digits_r[3]);
    out_nxt.shown_count   = SHOWN_W'(digits_r[0]) * SHOWN_W'(1000)
                          + SHOWN_W'(digits_r[1]) * SHOWN_W'(100)
                          + SHOWN_W'(digits_r[2]) * SHOWN_W'(10)
                          + SHOWN_W'(digits_r[3]);
    out_nxt.is_running    = running_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THR_RESET;
      running_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < DIGITS; i++) begin
        digits_r[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
      if (accept) begin
        running_r   <= running_nxt;
        out_valid_r <= 1'b1;
        for (int i = 0; i < DIGITS; i++) begin
          digits_r[i] <= digits_nxt[i];
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

endmodule

>>> tb/sv/debounced_stopwatch_7seg_tb.sv
// Testbench for the debounced four-digit BCD stopwatch with seven-segment output.
// It holds a scoreboard class that predicts each displayed tick and the tasks that drive it.
// Depends on dsw_pkg and the debounced_stopwatch_7seg RTL.
`timescale 1ns / 1ps

class stopwatch_scoreboard;
  localparam int CNT_MAX = (1 << dsw_pkg::DEBOUNCE_BITS) - 1;
  localparam logic [69:0] GLYPHS = {7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D,
                                    7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};

  dsw_pkg::thr_t       threshold;
  dsw_pkg::press_cnt_t press_cnt[3];
  bit                  running;
  dsw_pkg::digit_t     digits[4];
  dsw_pkg::out_t       pending_readouts[$];
  int                  fails;

  function new();
    threshold = dsw_pkg::THR_RESET;
    foreach (press_cnt[i]) press_cnt[i] = '0;
    foreach (digits[i]) digits[i] = '0;
    running = 1'b0;
    fails = 0;
  endfunction

  function void write_threshold(dsw_pkg::thr_t value);
    threshold = value;
  endfunction

  function int pending();
    return pending_readouts.size();
  endfunction

  function void report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fails++;
  endfunction

  function dsw_pkg::seg_t glyph(dsw_pkg::digit_t d);
    if (d > 4'd9) return '0;
    return GLYPHS[d*7 +: 7];
  endfunction

  function bit press_fires(int idx, bit level);
    int thr;
    int cnt;
    thr = (threshold == 0) ? 1 : int'(threshold);
    cnt = int'(press_cnt[idx]);
    if (!level) begin
      press_cnt[idx] = '0;
      return 1'b0;
    end
    if (cnt < thr && cnt < CNT_MAX) begin
      cnt++;
      press_cnt[idx] = dsw_pkg::press_cnt_t'(cnt);
      return cnt == thr;
    end
    return 1'b0;
  endfunction

  function void note_tick(dsw_pkg::in_t tick);
    dsw_pkg::out_t readout;
    int shown;
    bit fire_start;
    bit fire_stop;
    bit fire_clear;
    readout.seg_thousands = glyph(digits[0]);
    readout.seg_hundreds  = glyph(digits[1]);
    readout.seg_tens      = glyph(digits[2]);
    readout.seg_units     = glyph(digits[3]);
    shown = ((int'(digits[0]) * 10 + int'(digits[1])) * 10 + int'(digits[2])) * 10
            + int'(digits[3]);
    readout.shown_count = shown[dsw_pkg::SHOWN_W-1:0];
    fire_start = press_fires(0, tick.start_pressed);
    fire_stop  = press_fires(1, tick.stop_pressed);
    fire_clear = press_fires(2, tick.clear_pressed);
    if (fire_start) running = 1'b1;
    if (fire_stop) running = 1'b0;
    if (fire_clear) begin
      running = 1'b0;
      foreach (digits[i]) digits[i] = '0;
    end
    if (running) begin
      for (int k = 3; k >= 0; k--) begin
        if (digits[k] >= 4'd9) begin
          digits[k] = '0;
        end else begin
          digits[k] = digits[k] + 4'd1;
          break;
        end
      end
    end
    readout.is_running = running;
    pending_readouts.push_back(readout);
  endfunction

  function void check_result(dsw_pkg::out_t got);
    dsw_pkg::out_t want;
    if (pending_readouts.size() == 0) begin
      report($sformatf("result 0x%h arrived with no tick outstanding", got));
      return;
    end
    want = pending_readouts.pop_front();
    if (got.seg_thousands !== want.seg_thousands)
      report($sformatf("seg_thousands got 0x%h expected 0x%h",
                       got.seg_thousands, want.seg_thousands));
    if (got.seg_hundreds !== want.seg_hundreds)
      report($sformatf("seg_hundreds got 0x%h expected 0x%h",
                       got.seg_hundreds, want.seg_hundreds));
    if (got.seg_tens !== want.seg_tens)
      report($sformatf("seg_tens got 0x%h expected 0x%h", got.seg_tens, want.seg_tens));
    if (got.seg_units !== want.seg_units)
      report($sformatf("seg_units got 0x%h expected 0x%h", got.seg_units, want.seg_units));
    if (got.shown_count !== want.shown_count)
      report($sformatf("shown_count got %0d expected %0d",
                       got.shown_count, want.shown_count));
    if (got.is_running !== want.is_running)
      report($sformatf("is_running got %b expected %b", got.is_running, want.is_running));
  endfunction
endclass

module debounced_stopwatch_7seg_tb;
  import dsw_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int PHASE_TICKS = 70;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  thr_t cfg_data;

  stopwatch_scoreboard sb;
  int  idle_cycles = 0;
  bit  steady = 1'b0;
  int  btn_left[3] = '{0, 0, 0};
  bit  btn_level[3] = '{1'b1, 1'b1, 1'b1};
  int  phase_thr[10] = '{2, 1, 3, 0, 4, 6, 1, 2, 5, 3};

  debounced_stopwatch_7seg dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Each button alternates between pressed and released runs, with pressed runs
  // clustered around the threshold; a few ticks are replaced by random levels.
  function automatic in_t random_tick(int thr);
    in_t t;
    int  r;
    for (int b = 0; b < 3; b++) begin
      if (btn_left[b] == 0) begin
        btn_level[b] = !btn_level[b];
        r = $urandom_range(99);
        if (btn_level[b]) begin
          if (r < 25) btn_left[b] = (thr > 1) ? thr - 1 : 1;
          else if (r < 75) btn_left[b] = thr + $urandom_range(0, 2);
          else if (r < 90) btn_left[b] = thr + $urandom_range(3, 20);
          else btn_left[b] = $urandom_range(1, 3);
        end else begin
          if (r < 50) btn_left[b] = $urandom_range(1, 3);
          else if (r < 85) btn_left[b] = $urandom_range(4, 12);
          else btn_left[b] = $urandom_range(13, 40);
          if (b == 2) btn_left[b] = btn_left[b] * 3;
        end
      end
      btn_left[b]--;
    end
    t.start_pressed = btn_level[0];
    t.stop_pressed  = btn_level[1];
    t.clear_pressed = btn_level[2];
    if ($urandom_range(9) == 0) t = in_t'($urandom_range(7));
    return t;
  endfunction

  task automatic send_tick(in_t item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic hold(bit s, bit p, bit c, int n);
    in_t t;
    t.start_pressed = s;
    t.stop_pressed  = p;
    t.clear_pressed = c;
    repeat (n) send_tick(t);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic set_threshold(thr_t value);
    drain();
    repeat (2) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      int n;
      n = $urandom_range(1, 30);
      out_ready <= 1'b1;
      repeat (n) @(negedge clk);
      n = pick_gap();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    logic moved;
    moved = 1'b0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        sb.write_threshold(cfg_data);
        moved = 1'b1;
      end
      if (out_valid && out_ready) begin
        sb.check_result(out_data);
        moved = 1'b1;
      end
      if (in_valid && in_ready) begin
        sb.note_tick(in_data);
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int thr;
    sb = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Default threshold: held button, start and stop together, all three together.
    hold(0, 0, 0, 2);
    hold(1, 0, 0, 5);
    hold(0, 0, 0, 3);
    hold(0, 1, 0, 2);
    hold(0, 0, 0, 1);
    hold(1, 1, 0, 3);
    hold(1, 0, 0, 3);
    hold(0, 0, 0, 2);
    hold(1, 1, 1, 3);

    // A press already past a lowered threshold must not fire until released.
    set_threshold(8'd5);
    hold(0, 0, 0, 1);
    hold(1, 0, 0, 4);
    set_threshold(8'd2);
    hold(1, 0, 0, 2);
    hold(0, 0, 0, 1);
    hold(1, 0, 0, 2);

    // A zero threshold acts as one.
    set_threshold(8'd0);
    hold(0, 0, 0, 1);
    hold(0, 1, 0, 2);
    hold(0, 0, 1, 1);

    set_threshold(8'd255);
    hold(0, 0, 0, 1);
    hold(1, 0, 0, 258);
    hold(0, 0, 0, 3);
    hold(0, 0, 1, 255);

    // A running count driven back to back with no gaps on either side.
    set_threshold(8'd1);
    steady = 1'b1;
    hold(0, 0, 0, 1);
    hold(1, 0, 0, 1);
    hold(0, 0, 0, 50);
    steady = 1'b0;

    phase_thr[$urandom_range(9)] = $urandom_range(1, 8);
    foreach (phase_thr[i]) begin
      set_threshold(thr_t'(phase_thr[i]));
      thr = (phase_thr[i] == 0) ? 1 : phase_thr[i];
      steady = ($urandom_range(3) == 0);
      repeat (PHASE_TICKS) send_tick(random_tick(thr));
      steady = 1'b0;
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
